// ----- hw/rtl/indexed_free_list_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed free-list allocator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define INDEXED_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define IFLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define IFLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator next-cycle check failed");
`else
`define IFLA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IFLA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/ifla_pkg.sv -----
// ----------------------------------------------------------------------------
// ifla_pkg
// Widths, codes and write-port types of the indexed free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ifla_pkg;

  // Pool geometry: an index addresses one entry, a link can also hold null.
  localparam int IDX_W      = 10;
  localparam int LINK_W     = IDX_W + 1;
  localparam int POOL_DEPTH = 1 << IDX_W;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 24;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  localparam link_t NULL_LINK = link_t'(POOL_DEPTH);

  // Request actions.
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_TAKE  = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  // Result status codes.
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_EMPTY  = 2'd1;
  localparam logic [1:0] STS_MISUSE = 2'd2;

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_WB    = 2'd3;

  // One write to a link memory.
  typedef struct packed {
    logic  en;
    idx_t  addr;
    link_t data;
  } link_write_t;

  // One write to the allocated-mark memory.
  typedef struct packed {
    logic en;
    idx_t addr;
    logic data;
  } mark_write_t;

  // Bring a written pool length into the range 1 to POOL_DEPTH.
  function automatic link_t clamp_len(input link_t v);
    link_t r;
    r = v;
    if (v == link_t'(0)) begin
      r = link_t'(1);
    end else if (v > NULL_LINK) begin
      r = NULL_LINK;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/indexed_free_list_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// indexed_free_list_allocator_unit
// Entry allocator whose free entries form a doubly linked list kept in
// next and previous link memories, with a per-entry allocated mark.
// ----------------------------------------------------------------------------
// A taken request word passes through the execute and write-back states; its result
// word is registered as write-back ends, which waits until the prior result is taken.
// No new request is taken before that, as the single write port of each link memory
// splits read, execute and link write-back. Reset and every pool_length write start
// a clearing pass over every entry that rebuilds the free list in index order; no
// request is taken during it. Reset is synchronous and active low.
`default_nettype none

`include "indexed_free_list_allocator_unit_macros.svh"

module indexed_free_list_allocator_unit import ifla_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration: pool_length
  input  wire logic              cfg_wr_en,
  input  wire logic [LINK_W-1:0] cfg_wr_data,
  // Request words
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,   // action[1:0], entry_index[11:2], zero pad
  // Result words
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata   // status[1:0], granted_index[11:2],
                                             // is_allocated[12], in_use_count[23:13]
);

  // Link and mark storage.
  link_t next_mem [POOL_DEPTH];
  link_t prev_mem [POOL_DEPTH];
  logic  mark_mem [POOL_DEPTH];

  logic [1:0]  state_r;
  idx_t        sweep_r;
  link_t       len_r;
  link_t       head_r, tail_r, cnt_r;
  link_t       head_nxt, tail_nxt, cnt_nxt;
  logic [1:0]  act_r;
  idx_t        idx_r, e_r;
  link_t       rd_next_r, rd_prev_r;
  logic        rd_mark_r;
  link_write_t wb_next_r, wb_prev_r, wb_next_nxt, wb_prev_nxt;
  link_write_t ex_next, ex_prev, next_w, prev_w;
  mark_write_t ex_mark, mark_w;
  logic [OUT_W-1:0] res_r, res_nxt, out_data_r;
  logic        out_valid_r, out_valid_nxt;

  logic        in_fire, out_free;
  idx_t        rd_addr;
  link_t       sweep_next, sweep_prev, sweep_inc;
  link_t       len_cfg;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign len_cfg    = clamp_len(cfg_wr_data);

  // Allocate reads the head entry while the list is non-empty; everything else reads the named entry.
  always_comb begin
    if (in_tdata[1:0] == ACT_ALLOC && head_r != NULL_LINK) begin
      rd_addr = head_r[IDX_W-1:0];
    end else begin
      rd_addr = in_tdata[IDX_W+1:2];
    end
  end

  // Chain values written by the clearing pass.
  always_comb begin
    sweep_inc  = {1'b0, sweep_r} + link_t'(1);
    sweep_next = (sweep_inc < len_r) ? sweep_inc : NULL_LINK;
    sweep_prev = (sweep_r == idx_t'(0)) ? NULL_LINK : ({1'b0, sweep_r} - link_t'(1));
  end

  // Execute step: decide the request from the words read out of the memories.
  always_comb begin
    logic  in_pool, head_null, p_null, n_null, ok, do_unlink, do_append, is_alloc;
    logic [1:0] status;
    idx_t  granted;
    in_pool   = {1'b0, idx_r} < len_r;
    head_null = (head_r == NULL_LINK);
    p_null    = (rd_prev_r == NULL_LINK);
    n_null    = (rd_next_r == NULL_LINK);
    do_unlink = 1'b0;
    do_append = 1'b0;
    status    = STS_OK;
    granted   = idx_r;
    case (act_r)
      ACT_ALLOC: begin
        if (head_null) begin
          status = STS_EMPTY;
        end else begin
          granted   = e_r;
          do_unlink = 1'b1;
        end
      end
      ACT_TAKE: begin
        if (!in_pool || rd_mark_r) begin
          status = STS_MISUSE;
        end else begin
          do_unlink = 1'b1;
        end
      end
      ACT_FREE: begin
        if (!in_pool || !rd_mark_r || cnt_r == link_t'(0)) begin
          status = STS_MISUSE;
        end else begin
          do_append = 1'b1;
        end
      end
      default: begin
        if (!in_pool) begin
          status = STS_MISUSE;
        end
      end
    endcase
    ok = (status == STS_OK);

    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    ex_next     = '{en: 1'b0, addr: e_r, data: NULL_LINK};
    ex_prev     = '{en: 1'b0, addr: e_r, data: NULL_LINK};
    ex_mark     = '{en: 1'b0, addr: e_r, data: 1'b0};
    wb_next_nxt = '{en: 1'b0, addr: rd_prev_r[IDX_W-1:0], data: rd_next_r};
    wb_prev_nxt = '{en: 1'b0, addr: rd_next_r[IDX_W-1:0], data: rd_prev_r};

    if (do_unlink) begin
      // Detach the entry now, bridge its neighbors in the write-back cycle.
      ex_next.en     = 1'b1;
      ex_prev.en     = 1'b1;
      ex_mark        = '{en: 1'b1, addr: e_r, data: 1'b1};
      wb_next_nxt.en = !p_null;
      wb_prev_nxt.en = !n_null;
      if (p_null) begin
        head_nxt = rd_next_r;
      end
      if (n_null) begin
        tail_nxt = rd_prev_r;
      end
      cnt_nxt = cnt_r + link_t'(1);
    end else if (do_append) begin
      // Entry becomes the new tail; old tail points to it in write-back.
      ex_next.en  = 1'b1;
      ex_prev     = '{en: 1'b1, addr: e_r, data: (head_null ? NULL_LINK : tail_r)};
      ex_mark     = '{en: 1'b1, addr: e_r, data: 1'b0};
      wb_next_nxt = '{en: !head_null, addr: tail_r[IDX_W-1:0], data: {1'b0, e_r}};
      tail_nxt    = {1'b0, e_r};
      if (head_null) begin
        head_nxt = {1'b0, e_r};
      end
      cnt_nxt = cnt_r - link_t'(1);
    end

    if (ok && (act_r == ACT_ALLOC || act_r == ACT_TAKE)) begin
      is_alloc = 1'b1;
    end else if (ok && act_r == ACT_FREE) begin
      is_alloc = 1'b0;
    end else begin
      is_alloc = in_pool && rd_mark_r;
    end
    res_nxt = {cnt_nxt, is_alloc, granted, status};
  end

  // Write-port selection for the three memories.
  always_comb begin
    next_w = '{en: 1'b0, addr: sweep_r, data: sweep_next};
    prev_w = '{en: 1'b0, addr: sweep_r, data: sweep_prev};
    mark_w = '{en: 1'b0, addr: sweep_r, data: 1'b0};
    case (state_r)
      ST_CLEAR: begin
        next_w.en = 1'b1;
        prev_w.en = 1'b1;
        mark_w.en = 1'b1;
      end
      ST_EXEC: begin
        next_w = ex_next;
        prev_w = ex_prev;
        mark_w = ex_mark;
      end
      ST_WB: begin
        next_w = wb_next_r;
        prev_w = wb_prev_r;
      end
      default: begin
      end
    endcase
  end

  // Result valid: drops when the word is taken, rises when write-back ends.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (!cfg_wr_en && state_r == ST_WB && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Memories: at most one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (next_w.en) begin
      next_mem[next_w.addr] <= next_w.data;
    end
    rd_next_r <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_w.en) begin
      prev_mem[prev_w.addr] <= prev_w.data;
    end
    rd_prev_r <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mark_w.en) begin
      mark_mem[mark_w.addr] <= mark_w.data;
    end
    rd_mark_r <= mark_mem[rd_addr];
  end

  // Sequencer and list bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      len_r       <= NULL_LINK;
      head_r      <= '0;
      tail_r      <= NULL_LINK - link_t'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        len_r   <= len_cfg;
        head_r  <= '0;
        tail_r  <= len_cfg - link_t'(1);
        cnt_r   <= '0;
        sweep_r <= '0;
        state_r <= ST_CLEAR;
      end else begin
        case (state_r)
          ST_CLEAR: begin
            sweep_r <= sweep_r + idx_t'(1);
            if (sweep_r == idx_t'(POOL_DEPTH - 1)) begin
              state_r <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_fire) begin
              state_r <= ST_EXEC;
            end
          end
          ST_EXEC: begin
            head_r  <= head_nxt;
            tail_r  <= tail_nxt;
            cnt_r   <= cnt_nxt;
            state_r <= ST_WB;
          end
          ST_WB: begin
            if (out_free) begin
              state_r <= ST_IDLE;
            end
          end
          default: begin
            state_r <= ST_IDLE;
          end
        endcase
      end
    end
  end

  // Request, write-back and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_tdata[1:0];
      idx_r <= in_tdata[IDX_W+1:2];
      e_r   <= rd_addr;
    end
    if (state_r == ST_EXEC) begin
      wb_next_r <= wb_next_nxt;
      wb_prev_r <= wb_prev_nxt;
      res_r     <= res_nxt;
    end
    if (state_r == ST_WB && out_free) begin
      out_data_r <= res_r;
    end
  end

  // The in-use count never exceeds the pool.
  `IFLA_ASSERT_IMP(a_cnt_in_pool, clk, rst_n, 1'b1, cnt_r <= len_r)
  // The list ends are null together.
  `IFLA_ASSERT_IMP(a_ends_agree, clk, rst_n, 1'b1,
                   (head_r == NULL_LINK) == (tail_r == NULL_LINK))
  // An empty report only comes when every entry is in use.
  `IFLA_ASSERT_IMP(a_empty_full, clk, rst_n,
                   out_valid_r && out_data_r[1:0] == STS_EMPTY,
                   out_data_r[OUT_W-1:OUT_W-LINK_W] == len_r)
  // A pool_length write restarts the clearing pass with nothing in use.
  `IFLA_ASSERT_NXT(a_cfg_clears, clk, rst_n, cfg_wr_en,
                   state_r == ST_CLEAR && sweep_r == idx_t'(0) && cnt_r == link_t'(0))

endmodule

`default_nettype wire
